>>> design/pst_pkg.sv
// shared types, constants and the fnv step for the page stability tracker
package pst_pkg;

	localparam int PAGE_COUNT = 1024;
	localparam int PAGE_BYTES = 4096;
	localparam int PAGE_AW    = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
	localparam int PADDR_W    = 3;

	localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
	localparam logic [7:0]  BYTE_ZERO = 8'h00;
	localparam logic [7:0]  BYTE_CC   = 8'hCC;
	localparam logic [7:0]  THR_RESET = 8'd3;
	localparam logic [7:0]  COUNT_MAX = 8'hFF;

	// register index decoded from paddr above the byte offset
	localparam logic REG_THRESHOLD = 1'b0;

	typedef logic [1:0] page_status_t;
	localparam page_status_t ST_NEW       = 2'd0;
	localparam page_status_t ST_PENDING   = 2'd1;
	localparam page_status_t ST_CONFIRMED = 2'd2;
	localparam page_status_t ST_EVICTED   = 2'd3;

	typedef logic [2:0] verdict_t;
	localparam verdict_t V_SKIPPED   = 3'd0;
	localparam verdict_t V_FAILED    = 3'd1;
	localparam verdict_t V_BLANK     = 3'd2;
	localparam verdict_t V_EVICTED   = 3'd3;
	localparam verdict_t V_ENCRYPTED = 3'd4;
	localparam verdict_t V_FIRST     = 3'd5;
	localparam verdict_t V_CONFIRMED = 3'd6;
	localparam verdict_t V_REWRITE   = 3'd7;

	typedef struct packed {
		logic clr_en;
		logic byte_en;
		logic lookup_en;
		logic judge_en;
	} pst_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic out_full;
	} pst_stat_t;

	// fnv-1a step; prime 0x100000001b3 as shifts: 2^40 + 0x1b3
	function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
		logic [63:0] x;
		x = h ^ {56'b0, b};
		return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

endpackage

>>> design/page_stability_tracker.sv
// Page stability tracker: a byte that is not last of its page is taken without a stall.
// After the last byte of a page the input stalls for table read and verdict, then the next byte;
// its result word is registered in the verdict state, which waits while the output is stalled.
// The table lookup through registered memory reads sets the per-page cost.
// After reset a clearing sweep over all PAGE_COUNT (1024) entries resets the page table;
// bytes are stalled during it, configuration writes are taken as ever.
module page_stability_tracker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [9:0]                  page_index,
	input  logic [7:0]                  data_byte,
	input  logic                        last_byte,
	input  logic                        read_failed,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [2:0]                  verdict,
	output logic [63:0]                 page_hash,
	output logic [9:0]                  result_page,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pst_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	pst_pkg::pst_cmd_t  cmd;
	pst_pkg::pst_stat_t stat;
	logic [7:0]         threshold;

	pst_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.threshold (threshold)
	);

	pst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_byte (last_byte),
		.in_stall  (in_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	pst_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.threshold   (threshold),
		.page_index  (page_index),
		.data_byte   (data_byte),
		.last_byte   (last_byte),
		.read_failed (read_failed),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.verdict     (verdict),
		.page_hash   (page_hash),
		.result_page (result_page)
	);

endmodule

>>> design/pst_regs.sv
// configuration register file on the apb-style port
module pst_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pst_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output logic [7:0]                  threshold
);

	logic [7:0] thr_q;
	logic       hit;

	assign hit    = (paddr[pst_pkg::PADDR_W-1:2] == pst_pkg::REG_THRESHOLD);
	assign pready = 1'b1;
	assign prdata = hit ? {24'b0, thr_q} : 32'b0;
	assign threshold = thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= pst_pkg::THR_RESET;
		end else if (psel && penable && pwrite && hit) begin
			thr_q <= pwdata[7:0];
		end
	end

endmodule

>>> design/pst_dp.sv
// datapath: running hash, page flags, page table memories, verdict and output word
module pst_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  pst_pkg::pst_cmd_t   cmd,
	output pst_pkg::pst_stat_t  stat,
	input  logic [7:0]          threshold,
	input  logic [9:0]          page_index,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	input  logic                read_failed,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [2:0]          verdict,
	output logic [63:0]         page_hash,
	output logic [9:0]          result_page
);

	localparam int AW = pst_pkg::PAGE_AW;

	// table memories: status and blank count together, hash apart
	logic [9:0]  meta_mem [pst_pkg::PAGE_COUNT];
	logic [63:0] hash_mem [pst_pkg::PAGE_COUNT];

	logic [63:0] run_hash_q;
	logic        zero_q;
	logic        cc_q;
	logic [63:0] hash_next;

	logic [63:0] fin_hash_q;
	logic        blank_q;
	logic        enc_q;
	logic        failed_q;
	logic [9:0]  page_q;

	logic [9:0]  meta_rd_q;
	logic [63:0] hash_rd_q;
	logic [AW-1:0] clr_cnt_q;

	logic                  out_valid_q;
	pst_pkg::verdict_t     verdict_q;
	logic [63:0]           page_hash_q;
	logic [9:0]            result_page_q;

	pst_pkg::page_status_t st;
	logic [7:0]            cnt;
	logic [7:0]            cnt_inc;
	logic                  page_ok;
	pst_pkg::verdict_t     v;
	pst_pkg::page_status_t st_new;
	logic [7:0]            cnt_new;
	logic                  meta_upd;
	logic                  hash_upd;

	logic          meta_we;
	logic [AW-1:0] waddr;
	logic [9:0]    meta_wdata;

	assign hash_next = pst_pkg::fnv_step(run_hash_q, data_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_hash_q <= pst_pkg::FNV_BASIS;
			zero_q     <= 1'b1;
			cc_q       <= 1'b1;
		end else if (cmd.byte_en) begin
			if (last_byte) begin
				run_hash_q <= pst_pkg::FNV_BASIS;
				zero_q     <= 1'b1;
				cc_q       <= 1'b1;
			end else begin
				run_hash_q <= hash_next;
				zero_q     <= zero_q && (data_byte == pst_pkg::BYTE_ZERO);
				cc_q       <= cc_q && (data_byte == pst_pkg::BYTE_CC);
			end
		end
	end

	// finished page word, held until judged
	always_ff @(posedge clk) begin
		if (cmd.byte_en && last_byte) begin
			fin_hash_q <= hash_next;
			blank_q    <= zero_q && (data_byte == pst_pkg::BYTE_ZERO);
			enc_q      <= cc_q && (data_byte == pst_pkg::BYTE_CC);
			failed_q   <= read_failed;
			page_q     <= page_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_en) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
		end
	end

	assign page_ok = (32'(page_q) < pst_pkg::PAGE_COUNT);

	always_ff @(posedge clk) begin
		if (cmd.lookup_en) begin
			meta_rd_q <= meta_mem[page_q[AW-1:0]];
			hash_rd_q <= hash_mem[page_q[AW-1:0]];
		end
	end

	assign st      = meta_rd_q[9:8];
	assign cnt     = meta_rd_q[7:0];
	assign cnt_inc = (cnt != pst_pkg::COUNT_MAX) ? cnt + 8'd1 : cnt;

	always_comb begin
		v        = pst_pkg::V_SKIPPED;
		st_new   = st;
		cnt_new  = cnt;
		meta_upd = 1'b0;
		hash_upd = 1'b0;
		if (!page_ok || st == pst_pkg::ST_CONFIRMED || st == pst_pkg::ST_EVICTED) begin
			v = pst_pkg::V_SKIPPED;
		end else if (failed_q) begin
			v = pst_pkg::V_FAILED;
		end else if (blank_q) begin
			meta_upd = 1'b1;
			if (cnt_inc >= threshold) begin
				st_new  = pst_pkg::ST_EVICTED;
				cnt_new = 8'd0;
				v       = pst_pkg::V_EVICTED;
			end else begin
				cnt_new = cnt_inc;
				v       = pst_pkg::V_BLANK;
			end
		end else if (enc_q) begin
			v = pst_pkg::V_ENCRYPTED;
		end else begin
			meta_upd = 1'b1;
			cnt_new  = 8'd0;
			if (st == pst_pkg::ST_NEW) begin
				hash_upd = 1'b1;
				st_new   = pst_pkg::ST_PENDING;
				v        = pst_pkg::V_FIRST;
			end else if (hash_rd_q == fin_hash_q) begin
				st_new = pst_pkg::ST_CONFIRMED;
				v      = pst_pkg::V_CONFIRMED;
			end else begin
				hash_upd = 1'b1;
				v        = pst_pkg::V_REWRITE;
			end
		end
	end

	// one write port, shared by the clearing sweep and the verdict update
	assign meta_we    = cmd.clr_en || (cmd.judge_en && meta_upd);
	assign waddr      = cmd.clr_en ? clr_cnt_q : page_q[AW-1:0];
	assign meta_wdata = cmd.clr_en ? 10'd0 : {st_new, cnt_new};

	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[waddr] <= meta_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.judge_en && hash_upd) begin
			hash_mem[page_q[AW-1:0]] <= fin_hash_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.judge_en) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.judge_en) begin
			verdict_q     <= v;
			page_hash_q   <= fin_hash_q;
			result_page_q <= page_q;
		end
	end

	assign stat.clr_done = (clr_cnt_q == AW'(pst_pkg::PAGE_COUNT - 1));
	assign stat.out_full = out_valid_q && out_stall;

	assign out_valid   = out_valid_q;
	assign verdict     = verdict_q;
	assign page_hash   = page_hash_q;
	assign result_page = result_page_q;

endmodule

>>> design/pst_ctrl.sv
// controller: clearing sweep, byte intake, table lookup and verdict sequencing
module pst_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               last_byte,
	output logic               in_stall,
	input  pst_pkg::pst_stat_t stat,
	output pst_pkg::pst_cmd_t  cmd
);

	localparam logic [1:0] S_CLEAR  = 2'd0;
	localparam logic [1:0] S_RUN    = 2'd1;
	localparam logic [1:0] S_LOOKUP = 2'd2;
	localparam logic [1:0] S_JUDGE  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_stall = (state_q != S_RUN);

	always_comb begin
		state_d       = state_q;
		cmd.clr_en    = 1'b0;
		cmd.byte_en   = 1'b0;
		cmd.lookup_en = 1'b0;
		cmd.judge_en  = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (stat.clr_done) begin
					state_d = S_RUN;
				end
			end
			S_RUN: begin
				cmd.byte_en = in_valid;
				if (in_valid && last_byte) begin
					state_d = S_LOOKUP;
				end
			end
			S_LOOKUP: begin
				cmd.lookup_en = 1'b1;
				state_d       = S_JUDGE;
			end
			S_JUDGE: begin
				// wait while the previous result word is still held
				if (!stat.out_full) begin
					cmd.judge_en = 1'b1;
					state_d      = S_RUN;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> design/pst_checker.sv
// port-level checks for the page stability tracker, bound to the top level
module pst_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [9:0]  page_index,
	input logic        last_byte,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  verdict,
	input logic [63:0] page_hash,
	input logic [9:0]  result_page
);

	// a held result word does not change
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(verdict) && $stable(page_hash)
			&& $stable(result_page))
		else $error("result word changed while stalled");

	// the cycle after a last byte no further byte is taken
	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_byte |=> in_stall)
		else $error("byte taken during page lookup");

	// with the output free, a last byte's word is registered through the lookup and verdict
	// states and so is seen on out_valid
	a_verdict_due: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_byte && !out_valid |-> ##3 out_valid)
		else $error("verdict missing after last byte");

	a_verdict_page: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_byte && !out_valid
			|-> ##3 (result_page == $past(page_index, 3)))
		else $error("verdict carries the wrong page");

endmodule

bind page_stability_tracker pst_checker u_pst_checker (.*);
